>>> rtl/core/swmad_pkg.sv
package swmad_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
  localparam int COUNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int HALF_BITS   = SAMPLE_BITS + 1;
  localparam int QUART_BITS  = SAMPLE_BITS + 2;
  localparam int PROD_BITS   = 41;

  localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd0;
  localparam logic [2:0] REG_MIN_FILL         = 3'd1;
  localparam logic [2:0] REG_JITTER_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_CLEAR_FRACTION   = 3'd3;

  localparam logic [6:0] RESET_WINDOW_LENGTH = 7'd64;
  localparam logic [6:0] RESET_MIN_FILL      = 7'd8;
  localparam logic [31:0] RESET_THRESHOLD    = 32'd100;
  localparam logic [8:0] RESET_FRACTION      = 9'd205;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL_LOAD,
    ST_SEL_CAP,
    ST_SEL_SCAN,
    ST_SEL_CHECK,
    ST_DEV,
    ST_DECIDE
  } state_t;

endpackage

>>> rtl/core/sliding_window_mad_jitter_detector.sv
// Sequence: a word below the minimum fill goes straight to the result stage once accepted.
// Otherwise, for a window fill of n, each of the two rank-count selections tries up to
// n candidates, each counted against the whole window, and a deviation pass between
// the two writes the absolute deviation of every sample to the scratch memory.
// The next word is taken once the block is idle, even while the previous result still
// waits on the output register.
// Reset (rst, synchronous) and writes to defined registers clear all counters and flags.
module sliding_window_mad_jitter_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] latency_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [32:0] window_median,
  output logic [32:0] window_mad,
  output logic        jitter_flag,
  output logic        spike_event,
  output logic        clear_event,
  output logic [31:0] sample_count,
  output logic [31:0] spike_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AB = swmad_pkg::ADDR_BITS;
  localparam int CB = swmad_pkg::COUNT_BITS;
  localparam int HB = swmad_pkg::HALF_BITS;
  localparam int QB = swmad_pkg::QUART_BITS;
  localparam int PB = swmad_pkg::PROD_BITS;

  // Configuration registers.
  logic [6:0]  window_length;
  logic [6:0]  min_fill;
  logic [31:0] jitter_threshold;
  logic [8:0]  clear_fraction;
  logic [PB-1:0] clear_product;

  // Window and scratch memories.
  logic [swmad_pkg::SAMPLE_BITS-1:0] sample_ring [swmad_pkg::WINDOW_MAX];
  logic [HB-1:0] deviation_scratch [swmad_pkg::WINDOW_MAX];
  logic [swmad_pkg::SAMPLE_BITS-1:0] ring_rdata;
  logic [HB-1:0] scr_rdata;
  logic [AB-1:0] rd_addr;

  // Stream state.
  logic [AB-1:0] write_pointer;
  logic [CB-1:0] fill_count;
  logic          was_jittery;
  logic [31:0]   sample_total;
  logic [31:0]   total_spikes;

  // Sequencer.
  swmad_pkg::state_t state, state_next;
  logic          phase;       // 0: median of samples, 1: median of deviations
  logic [CB-1:0] cnt_i;
  logic [CB-1:0] cnt_j;
  logic [CB-1:0] below;
  logic [CB-1:0] same;
  logic [HB-1:0] cand;
  logic [HB-1:0] hi_val;
  logic [HB-1:0] lo_val;
  logic          hi_found;
  logic          lo_found;
  logic [HB-1:0] med2;
  logic [QB-1:0] madq;

  logic [6:0]    eff_len;
  logic [AB-1:0] wp_eff;
  logic [CB-1:0] fill_next;
  logic [CB-1:0] mid;
  logic [CB-1:0] mid_lo;
  logic          need_lo;
  logic          hi_ok;
  logic          lo_ok;
  logic          sel_done;
  logic [HB-1:0] sel_rdata;
  logic [HB-1:0] half_sample;
  logic [HB-1:0] dev_value;
  logic          in_acc;
  logic          cfg_acc;
  logic          jitter_now;
  logic          clr_ok;

  assign in_acc  = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // A window length of zero acts as one, and anything above the memory depth saturates.
  always_comb begin
    if (window_length == 7'd0) begin
      eff_len = 7'd1;
    end else if (window_length > 7'(swmad_pkg::WINDOW_MAX)) begin
      eff_len = 7'(swmad_pkg::WINDOW_MAX);
    end else begin
      eff_len = window_length;
    end
  end

  assign wp_eff    = ({1'b0, write_pointer} >= eff_len) ? '0 : write_pointer;
  assign fill_next = (fill_count < eff_len) ? fill_count + 1'b1 : eff_len;

  // Rank targets: the upper middle, and for an even fill also the lower middle.
  assign mid     = {1'b0, fill_count[CB-1:1]};
  assign mid_lo  = mid - 1'b1;
  assign need_lo = ~fill_count[0];
  assign hi_ok   = (below <= mid) && (mid < below + same);
  assign lo_ok   = (below <= mid_lo) && (mid_lo < below + same);
  assign sel_done = (hi_found || hi_ok) && (!need_lo || lo_found || lo_ok);

  assign sel_rdata   = phase ? scr_rdata : {1'b0, ring_rdata};
  assign half_sample = {ring_rdata, 1'b0};
  assign dev_value   = (half_sample >= med2) ? half_sample - med2 : med2 - half_sample;

  assign jitter_now = madq > {jitter_threshold, 2'b00};
  assign clr_ok     = {1'b0, madq, 6'd0} < clear_product;

  always_comb begin
    case (state)
      swmad_pkg::ST_SEL_LOAD: rd_addr = cnt_i[AB-1:0];
      swmad_pkg::ST_SEL_SCAN: rd_addr = cnt_j[AB-1:0];
      swmad_pkg::ST_DEV:      rd_addr = cnt_i[AB-1:0];
      default:                rd_addr = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      swmad_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (fill_next >= min_fill) ? swmad_pkg::ST_SEL_LOAD
                                               : swmad_pkg::ST_DECIDE;
        end
      end
      swmad_pkg::ST_SEL_LOAD: state_next = swmad_pkg::ST_SEL_CAP;
      swmad_pkg::ST_SEL_CAP:  state_next = swmad_pkg::ST_SEL_SCAN;
      swmad_pkg::ST_SEL_SCAN: begin
        if (cnt_j == fill_count) begin
          state_next = swmad_pkg::ST_SEL_CHECK;
        end
      end
      swmad_pkg::ST_SEL_CHECK: begin
        if (!sel_done) begin
          state_next = swmad_pkg::ST_SEL_LOAD;
        end else if (phase) begin
          state_next = swmad_pkg::ST_DECIDE;
        end else begin
          state_next = swmad_pkg::ST_DEV;
        end
      end
      swmad_pkg::ST_DEV: begin
        if (cnt_i == fill_count) begin
          state_next = swmad_pkg::ST_SEL_LOAD;
        end
      end
      swmad_pkg::ST_DECIDE: begin
        if (!out_valid || out_ready) begin
          state_next = swmad_pkg::ST_IDLE;
        end
      end
      default: state_next = swmad_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state == swmad_pkg::ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmad_pkg::ST_IDLE;
    end else if (cfg_acc) begin
      state <= swmad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memories: the ring is written on each accepted word, scratch during the deviation pass.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_ring[wp_eff] <= latency_sample[swmad_pkg::SAMPLE_BITS-1:0];
    end
    ring_rdata <= sample_ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == swmad_pkg::ST_DEV && cnt_i != '0) begin
      deviation_scratch[AB'(cnt_i - 1'b1)] <= dev_value;
    end
    scr_rdata <= deviation_scratch[rd_addr];
  end

  // Product used by the clear test; the registers are stable long before it is needed.
  always_ff @(posedge clk) begin
    clear_product <= PB'(jitter_threshold) * PB'(clear_fraction);
  end

  // Configuration and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= swmad_pkg::RESET_WINDOW_LENGTH;
      min_fill         <= swmad_pkg::RESET_MIN_FILL;
      jitter_threshold <= swmad_pkg::RESET_THRESHOLD;
      clear_fraction   <= swmad_pkg::RESET_FRACTION;
    end else if (cfg_acc) begin
      case (cfg_index)
        swmad_pkg::REG_WINDOW_LENGTH:    window_length    <= cfg_data[6:0];
        swmad_pkg::REG_MIN_FILL:         min_fill         <= cfg_data[6:0];
        swmad_pkg::REG_JITTER_THRESHOLD: jitter_threshold <= cfg_data;
        swmad_pkg::REG_CLEAR_FRACTION:   clear_fraction   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Only a write to a defined register clears the stream state.
  always_ff @(posedge clk) begin
    if (rst || (cfg_acc && cfg_index <= swmad_pkg::REG_CLEAR_FRACTION)) begin
      write_pointer <= '0;
      fill_count    <= '0;
      was_jittery   <= 1'b0;
      sample_total  <= '0;
      total_spikes  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_acc) begin
        write_pointer <= ({1'b0, wp_eff} + 7'd1 >= eff_len) ? '0 : wp_eff + 1'b1;
        fill_count    <= fill_next;
        sample_total  <= sample_total + 32'd1;
      end
      if (state == swmad_pkg::ST_DECIDE && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        was_jittery <= jitter_now;
        if (jitter_now && !was_jittery) begin
          total_spikes <= total_spikes + 32'd1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Selection and deviation datapath.
  always_ff @(posedge clk) begin
    case (state)
      swmad_pkg::ST_IDLE: begin
        phase    <= 1'b0;
        cnt_i    <= '0;
        hi_found <= 1'b0;
        lo_found <= 1'b0;
        med2     <= '0;
        madq     <= '0;
      end
      swmad_pkg::ST_SEL_CAP: begin
        cand  <= sel_rdata;
        cnt_j <= '0;
        below <= '0;
        same  <= '0;
      end
      swmad_pkg::ST_SEL_SCAN: begin
        // Data for entry cnt_j-1 arrives while entry cnt_j is being addressed.
        if (cnt_j != '0) begin
          if (sel_rdata < cand) begin
            below <= below + 1'b1;
          end else if (sel_rdata == cand) begin
            same <= same + 1'b1;
          end
        end
        cnt_j <= cnt_j + 1'b1;
      end
      swmad_pkg::ST_SEL_CHECK: begin
        if (sel_done) begin
          cnt_i    <= '0;
          hi_found <= 1'b0;
          lo_found <= 1'b0;
        end else begin
          if (hi_ok && !hi_found) begin
            hi_val   <= cand;
            hi_found <= 1'b1;
          end
          if (lo_ok && !lo_found) begin
            lo_val   <= cand;
            lo_found <= 1'b1;
          end
          cnt_i <= cnt_i + 1'b1;
        end
      end
      swmad_pkg::ST_DEV: begin
        if (cnt_i == fill_count) begin
          cnt_i <= '0;
          phase <= 1'b1;
        end else begin
          cnt_i <= cnt_i + 1'b1;
        end
      end
      default: ;
    endcase
    // Finish a selection: the values found are written through the same cycle.
    if (state == swmad_pkg::ST_SEL_CHECK && sel_done) begin
      if (phase) begin
        madq <= (need_lo ? {1'b0, (hi_found ? hi_val : cand)} +
                           {1'b0, (lo_found ? lo_val : cand)}
                         : {(hi_found ? hi_val : cand), 1'b0});
      end else begin
        med2 <= HB'(need_lo ? (hi_found ? hi_val : cand) + (lo_found ? lo_val : cand)
                            : {(hi_found ? hi_val : cand), 1'b0});
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == swmad_pkg::ST_DECIDE && (!out_valid || out_ready)) begin
      window_median <= med2;
      window_mad    <= madq[QB-1:1];
      jitter_flag   <= jitter_now;
      spike_event   <= jitter_now && !was_jittery;
      clear_event   <= !jitter_now && was_jittery && clr_ok;
      sample_count  <= sample_total;
      spike_count   <= (jitter_now && !was_jittery) ? total_spikes + 32'd1 : total_spikes;
    end
  end

endmodule

>>> tb/sv/tb_sliding_window_mad_jitter_detector.sv
`timescale 1ns / 1ps

module tb_sliding_window_mad_jitter_detector;

  // One result word of the detector, field for field as the ports carry it.
  typedef struct {
    logic [32:0] med;
    logic [32:0] mad;
    logic        jit;
    logic        spk;
    logic        clr;
    logic [31:0] scnt;
    logic [31:0] spcnt;
  } verdict_t;

  // A directed row either sends a sample checked by the predictor, sends a sample
  // whose result is typed in, or writes a configuration register.
  typedef enum {ROW_SAMPLE, ROW_TYPED, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] sample;
    logic [2:0]  idx;
    logic [31:0] data;
    verdict_t    v;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] latency_sample;
  logic        out_valid;
  logic        out_ready;
  logic [32:0] window_median;
  logic [32:0] window_mad;
  logic        jitter_flag;
  logic        spike_event;
  logic        clear_event;
  logic [31:0] sample_count;
  logic [31:0] spike_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  sliding_window_mad_jitter_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .latency_sample(latency_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .window_median(window_median), .window_mad(window_mad),
    .jitter_flag(jitter_flag), .spike_event(spike_event), .clear_event(clear_event),
    .sample_count(sample_count), .spike_count(spike_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the window history.
  logic [6:0]        win_len_r;
  logic [6:0]        min_fill_r;
  logic [31:0]       thr_r;
  logic [8:0]        frac_r;
  longint unsigned   ring_m [swmad_pkg::WINDOW_MAX];
  int unsigned       wr_ptr_m;
  int unsigned       fill_m;
  bit                was_jit_m;
  logic [31:0]       nsamp_m;
  logic [31:0]       nspike_m;

  verdict_t pending_verdicts[$];
  dir_row_t dir_table[$];
  int       error_count = 0;
  int       results_seen = 0;
  int       burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void clear_history();
    for (int i = 0; i < swmad_pkg::WINDOW_MAX; i++) ring_m[i] = 0;
    wr_ptr_m  = 0;
    fill_m    = 0;
    was_jit_m = 1'b0;
    nsamp_m   = '0;
    nspike_m  = '0;
  endfunction

  // k-th smallest (0-based) of the first n entries, by counting ranks.
  function automatic longint unsigned kth_smallest(
      input longint unsigned a[swmad_pkg::WINDOW_MAX], input int n, input int k);
    int below;
    int same;
    for (int i = 0; i < n; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < n; j++) begin
        if (a[j] < a[i]) below++;
        else if (a[j] == a[i]) same++;
      end
      if (below <= k && k < below + same) return a[i];
    end
    return 0;
  endfunction

  // Twice the median: the sum of the two middle values for an even count.
  function automatic longint unsigned median_x2(
      input longint unsigned a[swmad_pkg::WINDOW_MAX], input int n);
    longint unsigned hi;
    hi = kth_smallest(a, n, n / 2);
    if ((n % 2) == 0 && n / 2 > 0) return hi + kth_smallest(a, n, n / 2 - 1);
    return hi + hi;
  endfunction

  function automatic void apply_config(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      swmad_pkg::REG_WINDOW_LENGTH:    win_len_r  = data[6:0];
      swmad_pkg::REG_MIN_FILL:         min_fill_r = data[6:0];
      swmad_pkg::REG_JITTER_THRESHOLD: thr_r      = data;
      swmad_pkg::REG_CLEAR_FRACTION:   frac_r     = data[8:0];
      default:                         return;
    endcase
    clear_history();
  endfunction

  // Advances the predictor by one sample and returns the result it must produce.
  function automatic verdict_t predict_verdict(input logic [31:0] s);
    verdict_t        v;
    int unsigned     len;
    longint unsigned med2;
    longint unsigned madq;
    longint unsigned h;
    longint unsigned dev[swmad_pkg::WINDOW_MAX];
    longint unsigned thr64;
    bit              now_jit;
    med2  = 0;
    madq  = 0;
    thr64 = thr_r;
    for (int i = 0; i < swmad_pkg::WINDOW_MAX; i++) dev[i] = 0;
    len = (win_len_r == 0) ? 1 :
          ((win_len_r > swmad_pkg::WINDOW_MAX) ? swmad_pkg::WINDOW_MAX : win_len_r);
    if (wr_ptr_m >= len) wr_ptr_m = 0;
    ring_m[wr_ptr_m] = s;
    wr_ptr_m = (wr_ptr_m + 1) % len;
    if (fill_m < len) fill_m++;
    if (fill_m > len) fill_m = len;
    if (fill_m >= min_fill_r) begin
      med2 = median_x2(ring_m, fill_m);
      for (int i = 0; i < fill_m; i++) begin
        h = ring_m[i] << 1;
        dev[i] = (h >= med2) ? h - med2 : med2 - h;
      end
      madq = median_x2(dev, fill_m);
    end
    now_jit = madq > (thr64 << 2);
    v.spk = 1'b0;
    v.clr = 1'b0;
    if (now_jit && !was_jit_m) begin
      v.spk = 1'b1;
      nspike_m++;
    end else if (!now_jit && was_jit_m && (madq << 6) < thr64 * longint'(frac_r)) begin
      v.clr = 1'b1;
    end
    was_jit_m = now_jit;
    nsamp_m++;
    v.med   = med2[32:0];
    v.mad   = madq[33:1];
    v.jit   = now_jit;
    v.scnt  = nsamp_m;
    v.spcnt = nspike_m;
    return v;
  endfunction

  function automatic verdict_t typed_verdict(input logic [32:0] med, input logic [32:0] mad,
                                             input logic [31:0] scnt);
    verdict_t v;
    v.med   = med;
    v.mad   = mad;
    v.jit   = 1'b0;
    v.spk   = 1'b0;
    v.clr   = 1'b0;
    v.scnt  = scnt;
    v.spcnt = '0;
    return v;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [31:0] sample,
                                  input logic [2:0] idx, input logic [31:0] data,
                                  input verdict_t v);
    dir_row_t r;
    r.kind   = kind;
    r.sample = sample;
    r.idx    = idx;
    r.data   = data;
    r.v      = v;
    dir_table.push_back(r);
  endfunction

  // Offers one word and holds it until accepted. The valid is left high so that a
  // following word can go straight out; the caller lowers it for a gap.
  task automatic send_word(input logic [31:0] s, input bit typed, input verdict_t tv);
    verdict_t pv;
    in_valid       <= 1'b1;
    latency_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pv = predict_verdict(s);
    pending_verdicts.push_back(typed ? tv : pv);
  endtask

  // Burst shaping: between bursts the sender drops valid for a random gap.
  task automatic paced_send(input logic [31:0] s);
    int gap;
    verdict_t dummy;
    dummy = typed_verdict('0, '0, '0);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    send_word(s, 1'b0, dummy);
  endtask

  // Registers change only once the block has handed over every result.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_config(idx, data);
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Random sample around a base: mostly small jitter, sometimes a spike or noise.
  function automatic logic [31:0] pick_sample(input logic [31:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return base + $urandom_range(0, 20);
    if (r < 85) return base + $urandom_range(0, 100000);
    return $urandom;
  endfunction

  // Receiver: checks every accepted word against the oldest expectation, and
  // drives out_ready on its own pattern. Once, after forty results, it holds off
  // for a long stretch so that the block fills up and stalls its input.
  initial begin : receiver
    verdict_t exp_v;
    int       hold_left;
    bit       held;
    bit       choppy;
    hold_left = 0;
    held      = 1'b0;
    choppy    = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result word with no expectation waiting");
          error_count++;
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (window_median !== exp_v.med) begin
            $error("window_median expected %0d got %0d", exp_v.med, window_median);
            error_count++;
          end
          if (window_mad !== exp_v.mad) begin
            $error("window_mad expected %0d got %0d", exp_v.mad, window_mad);
            error_count++;
          end
          if (jitter_flag !== exp_v.jit) begin
            $error("jitter_flag expected %0d got %0d", exp_v.jit, jitter_flag);
            error_count++;
          end
          if (spike_event !== exp_v.spk) begin
            $error("spike_event expected %0d got %0d", exp_v.spk, spike_event);
            error_count++;
          end
          if (clear_event !== exp_v.clr) begin
            $error("clear_event expected %0d got %0d", exp_v.clr, clear_event);
            error_count++;
          end
          if (sample_count !== exp_v.scnt) begin
            $error("sample_count expected %0d got %0d", exp_v.scnt, sample_count);
            error_count++;
          end
          if (spike_count !== exp_v.spcnt) begin
            $error("spike_count expected %0d got %0d", exp_v.spcnt, spike_count);
            error_count++;
          end
        end
      end
      if ($urandom_range(0, 19) == 0) choppy = !choppy;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 40 && !held) begin
        held      = 1'b1;
        hold_left = 3000;
        out_ready <= 1'b0;
      end else begin
        out_ready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
    end
  end

  initial begin : stimulus
    verdict_t    none;
    logic [6:0]  len7;
    logic [31:0] base;
    int          n_items;
    none = typed_verdict('0, '0, '0);

    rst            = 1'b1;
    in_valid       = 1'b0;
    latency_sample = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    win_len_r      = swmad_pkg::RESET_WINDOW_LENGTH;
    min_fill_r     = swmad_pkg::RESET_MIN_FILL;
    thr_r          = swmad_pkg::RESET_THRESHOLD;
    frac_r         = swmad_pkg::RESET_FRACTION;
    clear_history();

    // Directed table. Below the minimum fill of eight after reset the outputs are
    // zero and only the sample count moves, so those results are typed in.
    add_row(ROW_TYPED, 32'h0000_0000, '0, '0, typed_verdict('0, '0, 32'd1));
    add_row(ROW_TYPED, 32'hFFFF_FFFF, '0, '0, typed_verdict('0, '0, 32'd2));
    add_row(ROW_TYPED, 32'd1, '0, '0, typed_verdict('0, '0, 32'd3));
    add_row(ROW_TYPED, 32'd2, '0, '0, typed_verdict('0, '0, 32'd4));
    add_row(ROW_TYPED, 32'hFFFF_FFFE, '0, '0, typed_verdict('0, '0, 32'd5));
    add_row(ROW_TYPED, 32'h8000_0000, '0, '0, typed_verdict('0, '0, 32'd6));
    add_row(ROW_TYPED, 32'h7FFF_FFFF, '0, '0, typed_verdict('0, '0, 32'd7));
    add_row(ROW_SAMPLE, 32'd5, '0, '0, none);
    // Three-entry window, computed from the first sample, threshold zero.
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_WINDOW_LENGTH, 32'd3, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_MIN_FILL, 32'd1, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_JITTER_THRESHOLD, 32'd0, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_CLEAR_FRACTION, 32'd256, none);
    add_row(ROW_TYPED, 32'd7, '0, '0, typed_verdict(33'd14, '0, 32'd1));
    add_row(ROW_TYPED, 32'd7, '0, '0, typed_verdict(33'd14, '0, 32'd2));
    add_row(ROW_SAMPLE, 32'hFFFF_FFFF, '0, '0, none);
    add_row(ROW_SAMPLE, 32'd0, '0, '0, none);
    // Calm, then a spike that the next sample does not end.
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_JITTER_THRESHOLD, 32'd10, none);
    add_row(ROW_TYPED, 32'd100, '0, '0, typed_verdict(33'd200, '0, 32'd1));
    add_row(ROW_TYPED, 32'd100, '0, '0, typed_verdict(33'd200, '0, 32'd2));
    add_row(ROW_TYPED, 32'd100, '0, '0, typed_verdict(33'd200, '0, 32'd3));
    add_row(ROW_SAMPLE, 32'd5000, '0, '0, none);
    add_row(ROW_SAMPLE, 32'd9000, '0, '0, none);
    add_row(ROW_SAMPLE, 32'd100, '0, '0, none);
    // Indexes past the last register are ignored and keep the history; the next sample gives a clear event.
    add_row(ROW_CONFIG, '0, 3'd4, 32'hFFFF_FFFF, none);
    add_row(ROW_CONFIG, '0, 3'd7, 32'h0, none);
    add_row(ROW_SAMPLE, 32'd100, '0, '0, none);
    // Window length zero acts as one; a minimum fill above the window is never met.
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_WINDOW_LENGTH, 32'd0, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_MIN_FILL, 32'd127, none);
    add_row(ROW_TYPED, 32'd42, '0, '0, typed_verdict('0, '0, 32'd1));
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_MIN_FILL, 32'd0, none);
    add_row(ROW_TYPED, 32'd42, '0, '0, typed_verdict(33'd84, '0, 32'd1));
    add_row(ROW_TYPED, 32'd0, '0, '0, typed_verdict('0, '0, 32'd2));
    // Oversized window saturates; fraction above one and the largest threshold.
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_WINDOW_LENGTH, 32'd127, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_MIN_FILL, 32'd2, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_CLEAR_FRACTION, 32'd511, none);
    add_row(ROW_CONFIG, '0, swmad_pkg::REG_JITTER_THRESHOLD, 32'hFFFF_FFFF, none);
    add_row(ROW_SAMPLE, 32'hFFFF_FFFF, '0, '0, none);
    add_row(ROW_SAMPLE, 32'd0, '0, '0, none);
    add_row(ROW_SAMPLE, 32'hFFFF_FFFF, '0, '0, none);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      case (dir_table[i].kind)
        ROW_CONFIG: write_register(dir_table[i].idx, dir_table[i].data);
        ROW_TYPED:  send_word(dir_table[i].sample, 1'b1, dir_table[i].v);
        default:    send_word(dir_table[i].sample, 1'b0, none);
      endcase
    end

    // Random phases. Most use small windows; the last one saturates the window
    // and only computes once the full 64 entries are in.
    for (int p = 0; p < 6; p++) begin
      len7 = (p < 5) ? 7'($urandom_range(1, 12)) : 7'd127;
      write_register(swmad_pkg::REG_WINDOW_LENGTH,
                     {25'($urandom_range(0, 32'h1FF_FFFF)), len7});
      write_register(swmad_pkg::REG_MIN_FILL,
                     {25'($urandom), (p < 5) ? 7'($urandom_range(0, len7)) : 7'd64});
      write_register(swmad_pkg::REG_JITTER_THRESHOLD,
                     (p == 3) ? $urandom : 32'($urandom_range(0, 40000)));
      write_register(swmad_pkg::REG_CLEAR_FRACTION, {23'($urandom), 9'($urandom)});
      base    = (p == 4) ? 32'hFFFF_0000 : $urandom_range(0, 100000);
      n_items = (p < 5) ? 5 : 66;
      for (int k = 0; k < n_items; k++) begin
        // Once, the sender stops and waits for the block to drain completely.
        if (p == 2 && k == 3) begin
          in_valid <= 1'b0;
          while (pending_verdicts.size() != 0) @(posedge clk);
          burst_left = 0;
        end
        paced_send(pick_sample(base));
      end
    end
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", pending_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/swmad_pkg.sv
rtl/core/sliding_window_mad_jitter_detector.sv
tb/sv/tb_sliding_window_mad_jitter_detector.sv
